// ----- hw/rtl/drop_shadow_alpha_composite_macros.svh -----
// ---------------------------------------------------------------------------
// Drop shadow compositor assertion macros
// Shared assertion wrappers, removed when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef DROP_SHADOW_ALPHA_COMPOSITE_MACROS_SVH
`define DROP_SHADOW_ALPHA_COMPOSITE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every edge outside reset.
`define DSAC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("dsac assertion failed");
// Checked on every edge, during reset too.
`define DSAC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("dsac assertion failed during or after reset");
`else
`define DSAC_ASSERT(lbl, prop)
`define DSAC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hw/rtl/dsac_pkg.sv -----
// ---------------------------------------------------------------------------
// Drop shadow compositor package
// Register indexes, reset values and fixed sizes of the compositor.
// ---------------------------------------------------------------------------
package dsac_pkg;
	localparam int COVERAGE_BITS_DEF = 16;
	localparam int COV_IN_W = 16;
	localparam int LANES = 4;
	localparam int QBITS = 9;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_RED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_GREEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_BLUE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_OPACITY = 3'd3;

	localparam logic [7:0] OPACITY_RESET = 8'd255;
	localparam logic [7:0] TINT_RESET = 8'd0;
endpackage

// ----- hw/rtl/drop_shadow_alpha_composite.sv -----
// Throughput: one pixel per clock; a stalled output holds the whole pipeline.
// The depth is set by three multiply stages, one setup stage and nine restoring divide stages.
// Reset clears all valid bits and sets tint to black and opacity to 255.
// Configuration writes are taken in any cycle and always accepted.
// ---------------------------------------------------------------------------
// Drop shadow alpha compositor
// Composites an RGBA8 pixel over a tinted, blurred shadow (source over).
// ---------------------------------------------------------------------------
`include "drop_shadow_alpha_composite_macros.svh"

module drop_shadow_alpha_composite #(
	parameter int COVERAGE_BITS = dsac_pkg::COVERAGE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// orig_red, orig_green, orig_blue, orig_alpha, shadow_coverage[15:0]
	input  logic [47:0]                     s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [31:0]                     m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dsac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);
	import dsac_pkg::*;

	localparam int CW = COVERAGE_BITS;
	localparam int PV_W = CW + 8;
	localparam int AN_W = CW + 16;
	localparam int N_W = CW + 24;
	localparam int X_W = CW + 25;
	localparam int R_W = CW + 26;
	localparam longint unsigned MV = (64'd1 << CW) - 64'd1;
	localparam longint unsigned M255 = 255 * MV;
	localparam longint unsigned DEN = 255 * 255 * MV;
	localparam longint unsigned THR = (DEN - 1) / 100000;
	localparam int DSTG = QBITS;

	// Configuration registers.
	logic [7:0] tint_q [0:2];
	logic [7:0] opacity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_q[0] <= TINT_RESET;
			tint_q[1] <= TINT_RESET;
			tint_q[2] <= TINT_RESET;
			opacity_q <= OPACITY_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SHADOW_RED:     tint_q[0] <= cfg_data;
				CFG_SHADOW_GREEN:   tint_q[1] <= cfg_data;
				CFG_SHADOW_BLUE:    tint_q[2] <= cfg_data;
				CFG_SHADOW_OPACITY: opacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances when the output stage is free or taken.
	logic en;
	logic vld_s1, vld_s2, vld_s3;
	logic div_vld_s [0:DSTG];

	assign en = !div_vld_s[DSTG] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 0; k <= DSTG; k++) div_vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			div_vld_s[0] <= vld_s3;
			for (int k = 1; k <= DSTG; k++) div_vld_s[k] <= div_vld_s[k-1];
		end
	end

	// Stage 1: saturate coverage and scale it by the opacity.
	logic [23:0]   cov_ext;
	logic [CW-1:0] cov_sat;
	logic [PV_W-1:0] pv_s1;
	logic [7:0]    alpha_s1;
	logic [7:0]    col_s1 [0:2];

	assign cov_ext = 24'(s_tdata[47:32]);
	assign cov_sat = (cov_ext > 24'(MV)) ? CW'(MV) : cov_ext[CW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			pv_s1 <= PV_W'(opacity_q) * PV_W'(cov_sat);
			alpha_s1 <= s_tdata[31:24];
			col_s1[0] <= s_tdata[7:0];
			col_s1[1] <= s_tdata[15:8];
			col_s1[2] <= s_tdata[23:16];
		end
	end

	// Stage 2: weight of the original and weight of the shadow.
	logic [AN_W-1:0] base_s2, spv_s2;
	logic [7:0]      col_s2 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			base_s2 <= AN_W'(alpha_s1) * AN_W'(M255);
			spv_s2 <= AN_W'(8'd255 - alpha_s1) * AN_W'(pv_s1);
			col_s2 <= col_s1;
		end
	end

	// Stage 3: alpha numerator and the color products.
	logic [AN_W-1:0] an_s3;
	logic [N_W-1:0]  bc_s3 [0:2];
	logic [N_W-1:0]  st_s3 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			an_s3 <= base_s2 + spv_s2;
			for (int i = 0; i < 3; i++) begin
				bc_s3[i] <= N_W'(base_s2) * N_W'(col_s2[i]);
				st_s3[i] <= N_W'(spv_s2) * N_W'(tint_q[i]);
			end
		end
	end

	logic [X_W-1:0] div_r_s [0:DSTG][0:LANES-1];
	logic [X_W-1:0] div_d_s [0:DSTG][0:LANES-1];
	logic [QBITS-1:0] div_q_s [0:DSTG][0:LANES-1];
	logic           div_zero_s [0:DSTG];

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 4: rounded dividends and divisors for the four lanes, and the
			// nearly transparent test.
			for (int i = 0; i < 3; i++) begin
				div_r_s[0][i] <= (X_W'(bc_s3[i] + st_s3[i]) << 1) + X_W'(an_s3);
				div_d_s[0][i] <= X_W'(an_s3) << 1;
				div_q_s[0][i] <= '0;
			end
			div_r_s[0][3] <= (X_W'(an_s3) << 1) + X_W'(M255);
			div_d_s[0][3] <= X_W'(M255) << 1;
			div_q_s[0][3] <= '0;
			div_zero_s[0] <= (64'(an_s3) <= THR);

			// Divide stages: one quotient bit per stage, most significant first.
			for (int k = 0; k < DSTG; k++) begin
				div_zero_s[k+1] <= div_zero_s[k];
				for (int l = 0; l < LANES; l++) begin
					logic [R_W-1:0] trial;
					logic           ge;
					trial = R_W'(div_d_s[k][l]) << (DSTG - 1 - k);
					ge = R_W'(div_r_s[k][l]) >= trial;
					div_r_s[k+1][l] <= ge ? X_W'(R_W'(div_r_s[k][l]) - trial)
					                      : div_r_s[k][l];
					div_d_s[k+1][l] <= div_d_s[k][l];
					div_q_s[k+1][l] <= {div_q_s[k][l][QBITS-2:0], ge};
				end
			end
		end
	end

	// Output: clamp to a byte, zero when nearly transparent.
	logic [7:0] out_byte [0:LANES-1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (div_zero_s[DSTG]) begin
				out_byte[l] = 8'd0;
			end else if (div_q_s[DSTG][l][QBITS-1]) begin
				out_byte[l] = 8'd255;
			end else begin
				out_byte[l] = div_q_s[DSTG][l][7:0];
			end
		end
	end

	assign m_tvalid = div_vld_s[DSTG];
	assign m_tdata = {out_byte[3], out_byte[2], out_byte[1], out_byte[0]};

	// A kept word's colour quotients never need the clamp.
	`DSAC_ASSERT(a_no_overflow,
		div_vld_s[DSTG] && !div_zero_s[DSTG] |-> !div_q_s[DSTG][0][QBITS-1] &&
		!div_q_s[DSTG][1][QBITS-1] && !div_q_s[DSTG][2][QBITS-1])
	// The remainder ends below the divisor in the red and alpha lanes.
	`DSAC_ASSERT(a_rem_below_div,
		div_vld_s[DSTG] && !div_zero_s[DSTG] |->
		div_r_s[DSTG][0] < div_d_s[DSTG][0] && div_r_s[DSTG][3] < div_d_s[DSTG][3])
	// A kept word never enters the divider with a zero divisor in the red lane.
	`DSAC_ASSERT(a_div_nonzero,
		div_vld_s[0] && !div_zero_s[0] |-> div_d_s[0][0] != '0)
	// No output word is shown in the cycle after reset.
	`DSAC_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !m_tvalid)
endmodule

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// Drop shadow compositor testbench
// Drives pixel words through the compositor with random idling on both sides,
// predicts each output word with exact integer arithmetic or takes a known result, and compares fields.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dsac_pkg::*;

	localparam int LATENCY = 13;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint COV_MAX = 65535;

	typedef struct packed {
		logic [15:0] coverage;
		logic [7:0]  alpha;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
	} pixel_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	// Directed row: pixel, optional known result.
	typedef struct {
		pixel_t px;
		bit     known;
		rgba_t  res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [31:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	drop_shadow_alpha_composite i_dut (.*);

	logic [7:0] tint_r, tint_g, tint_b, opacity;
	rgba_t composites_due[$];
	int errors = 0;
	int pixels_sent = 0;
	int pixels_checked = 0;
	int cycles = 0;
	bit long_hold = 0;
	bit bench_done = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] rounded_byte(longint unsigned num, longint unsigned den);
		longint unsigned q;
		q = (2 * num + den) / (2 * den);
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	// Exact source-over of the pixel on the tinted shadow.
	function automatic rgba_t composite(pixel_t px);
		longint unsigned pv, den, an, base, ia;
		rgba_t r;
		pv = longint'(opacity) * px.coverage;
		den = 255 * 255 * COV_MAX;
		ia = 255 - px.alpha;
		an = den - ia * (255 * COV_MAX - pv);
		if (an * 100000 < den || an == 0)
			return '0;
		base = 255 * COV_MAX * px.alpha;
		r.red   = rounded_byte(base * px.red   + ia * pv * tint_r, an);
		r.green = rounded_byte(base * px.green + ia * pv * tint_g, an);
		r.blue  = rounded_byte(base * px.blue  + ia * pv * tint_b, an);
		r.alpha = rounded_byte(an, 255 * COV_MAX);
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SHADOW_RED:     tint_r = val;
			CFG_SHADOW_GREEN:   tint_g = val;
			CFG_SHADOW_BLUE:    tint_b = val;
			CFG_SHADOW_OPACITY: opacity = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_shadow(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] p);
		write_reg(CFG_SHADOW_RED, r);
		write_reg(CFG_SHADOW_GREEN, g);
		write_reg(CFG_SHADOW_BLUE, b);
		write_reg(CFG_SHADOW_OPACITY, p);
	endtask

	// Stop offering words and wait until every expected word has come out.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (composites_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Offer one word; the expectation is queued at acceptance. With no idle
	// cycles drawn, the word follows the previous one directly.
	task automatic send_pixel(pixel_t px, bit known, rgba_t res);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		composites_due.push_back(known ? res : composite(px));
		pixels_sent++;
	endtask

	function automatic pixel_t random_pixel();
		pixel_t px;
		px = {16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255))};
		case ($urandom_range(0, 7))
			0: px.alpha = 0;
			1: px.alpha = 255;
			2: px.coverage = 0;
			3: px.coverage = 16'hFFFF;
			4: px.coverage = 16'($urandom_range(0, 16));
			default: ;
		endcase
		return px;
	endfunction

	// Receiver: random stalls, with one long hold-off on request.
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 0;
				repeat (60) @(negedge clk);
				long_hold = 0;
			end
			gap = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap != 0) begin
				m_tready <= 0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1;
		end
	end

	// Output checker.
	always @(posedge clk) begin
		rgba_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (composites_due.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
			end else begin
				want = composites_due.pop_front();
				pixels_checked++;
				if (got.red !== want.red)
					$display("%0t: red exp %0d got %0d", $time, want.red, got.red);
				if (got.green !== want.green)
					$display("%0t: green exp %0d got %0d", $time, want.green, got.green);
				if (got.blue !== want.blue)
					$display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue);
				if (got.alpha !== want.alpha)
					$display("%0t: alpha exp %0d got %0d", $time, want.alpha, got.alpha);
				if (got !== want)
					errors++;
			end
		end
	end

	initial begin
		row_t rows[$];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		tint_r = TINT_RESET;
		tint_g = TINT_RESET;
		tint_b = TINT_RESET;
		opacity = OPACITY_RESET;

		// Directed table with reset shadow (black, opacity one).
		rows.push_back('{'{16'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1, '0});
		rows.push_back('{'{16'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF}, 1, '0});
		rows.push_back('{'{16'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}});
		rows.push_back('{'{16'hFFFF, 8'hFF, 8'd10, 8'd20, 8'd30}, 1, '{8'hFF, 8'd10, 8'd20, 8'd30}});
		rows.push_back('{'{16'hFFFF, 8'd0, 8'hFF, 8'hFF, 8'hFF}, 1, '{8'hFF, 8'd0, 8'd0, 8'd0}});
		rows.push_back('{'{16'd1, 8'd0, 8'd9, 8'd9, 8'd9}, 0, '0});
		rows.push_back('{'{16'd2, 8'd0, 8'd9, 8'd9, 8'd9}, 0, '0});
		rows.push_back('{'{16'd3, 8'd0, 8'd9, 8'd9, 8'd9}, 0, '0});
		rows.push_back('{'{16'h8000, 8'd128, 8'hAA, 8'h55, 8'h0F}, 0, '0});
		rows.push_back('{'{16'h7FFF, 8'd1, 8'h01, 8'h80, 8'hFE}, 0, '0});
		foreach (rows[i]) send_pixel(rows[i].px, rows[i].known, rows[i].res);
		drain();

		// Tinted shadow; coverage near zero probes the transparent cutoff.
		set_shadow(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		for (int i = 0; i < 6; i++)
			send_pixel('{16'(i), 8'd0, 8'd0, 8'd0, 8'd0}, 0, '0);
		send_pixel('{16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0}, 1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_pixel('{16'h4000, 8'd100, 8'd0, 8'hFF, 8'd7}, 0, '0);
		drain();
		set_shadow(8'h12, 8'h34, 8'h56, 8'd0);
		send_pixel('{16'hFFFF, 8'd0, 8'd1, 8'd2, 8'd3}, 1, '0);
		send_pixel('{16'hFFFF, 8'd1, 8'd200, 8'd2, 8'd3}, 0, '0);
		drain();
		// Unknown register indexes are ignored.
		write_reg(3'd5, 8'hAB);
		write_reg(3'd7, 8'hCD);

		// Random phases with a fresh shadow each time.
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: set_shadow(8'd0, 8'd0, 8'd0, 8'd255);
				1: set_shadow(8'd255, 8'd255, 8'd255, 8'd1);
				default: set_shadow(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			if (phase == 3) long_hold = 1;
			for (int i = 0; i < 125; i++)
				send_pixel(random_pixel(), 0, '0);
			// Sender waits for every word in flight before reconfiguring.
			drain();
		end

		$display("Sent %0d pixels over 13 shadow settings, checked %0d words.",
			pixels_sent, pixels_checked);
		$display("Covered alpha and coverage extremes, near-transparent cutoff, stalls.");
		if (errors == 0 && composites_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ----- drop_shadow_alpha_composite.f -----
+incdir+hw/rtl
hw/rtl/dsac_pkg.sv
hw/rtl/drop_shadow_alpha_composite.sv
bench/testbench.sv
